// ===== hw/rtl/scar_pkg.sv =====
`default_nettype none

package scar_pkg;

   // input operation codes
   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_SERVICE = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   // command recognizer states
   typedef enum logic [3:0] {
      P_IDLE   = 4'd0,
      P_BANG   = 4'd1,
      P_R      = 4'd2,
      P_S      = 4'd3,
      P_T      = 4'd4,
      P_O      = 4'd5,
      P_K      = 4'd6,
      P_DONE_K = 4'd7,
      P_DONE_T = 4'd8
   } parse_state_type;

   // link machine states
   typedef enum logic [2:0] {
      L_IDLE   = 3'd0,
      L_REPORT = 3'd1,
      L_LOAD   = 3'd2,
      L_WAIT   = 3'd3,
      L_END    = 3'd4,
      L_ERROR  = 3'd5
   } link_state_type;

   // reply message kinds
   typedef enum logic [1:0] {
      MSG_REPORT = 2'd0,
      MSG_END    = 2'd1,
      MSG_WRONG  = 2'd2
   } msg_kind_type;

   // transmit sequencer phases
   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_HEAD  = 2'd1,
      BK_DIGIT = 2'd2,
      BK_TAIL  = 2'd3
   } back_phase_type;

   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_R    = 8'h52;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_T    = 8'h54;
   localparam logic [7:0] CH_O    = 8'h4F;
   localparam logic [7:0] CH_K    = 8'h4B;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;

   localparam int CFG_BITS = 16;
   localparam logic [CFG_BITS-1:0] RETRY_RESET = 16'd300;
   localparam int KIND_BITS = 2;
   localparam int QUEUE_DEPTH = 2;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [16:0] DIV10_MUL = 17'd52429;
   localparam int DIV10_SHIFT = 19;

   localparam int POS_BITS = 3;
   localparam logic [POS_BITS-1:0] TAIL_LAST = 3'd2;

   // decimal digits needed for the largest value of a given width
   function automatic int max_digits(input int bits);
      longint v;
      int n;
      v = (longint'(1) << bits) - 1;
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (v != 0) begin
            v = v / 10;
            n = n + 1;
         end
      end
      return n;
   endfunction

   // position of the last fixed leading byte of a message
   function automatic logic [POS_BITS-1:0] head_last(input msg_kind_type kind);
      logic [POS_BITS-1:0] r;
      case (kind)
         MSG_REPORT: r = 3'd4;
         MSG_END:    r = 3'd4;
         MSG_WRONG:  r = 3'd6;
         default:    r = 3'd0;
      endcase
      return r;
   endfunction

   // fixed leading text: "!ADC=", "END\r\n", "WRONG\r\n"
   function automatic logic [7:0] head_byte(input msg_kind_type kind,
                                            input logic [POS_BITS-1:0] pos);
      logic [7:0] r;
      r = CH_LF;
      case (kind)
         MSG_REPORT: begin
            case (pos)
               3'd0: r = CH_BANG;
               3'd1: r = 8'h41;
               3'd2: r = 8'h44;
               3'd3: r = 8'h43;
               default: r = 8'h3D;
            endcase
         end
         MSG_END: begin
            case (pos)
               3'd0: r = 8'h45;
               3'd1: r = 8'h4E;
               3'd2: r = 8'h44;
               3'd3: r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         MSG_WRONG: begin
            case (pos)
               3'd0: r = 8'h57;
               3'd1: r = CH_R;
               3'd2: r = CH_O;
               3'd3: r = 8'h4E;
               3'd4: r = 8'h47;
               3'd5: r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         default: r = CH_LF;
      endcase
      return r;
   endfunction

   // closing text of a report: "#\r\n"
   function automatic logic [7:0] tail_byte(input logic [POS_BITS-1:0] pos);
      logic [7:0] r;
      case (pos)
         3'd0:    r = CH_HASH;
         3'd1:    r = CH_CR;
         default: r = CH_LF;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_command_ack_responder.sv =====
// a reply's first byte passes the reply queue, phase register and output register
// throughput: one input item per cycle while the reply queue has room; replies leave
// at one byte per cycle unless stalled; 5-7 bytes for fixed text, 9-12 for a 12-bit report
// reports convert the sample at one digit per cycle, overlapped with the "!ADC=" text
// reset: synchronous, active high; clears control state only; retry_ticks returns to 300
`default_nettype none

module serial_command_ack_responder #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIMER_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic [SAMPLE_BITS-1:0]        req_adc_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [7:0]                         rsp_tx_byte,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [scar_pkg::CFG_BITS-1:0] csr_data
);
   import scar_pkg::*;

   localparam int ENTRY_BITS = KIND_BITS + SAMPLE_BITS;

   logic                    push;
   msg_kind_type            push_kind;
   logic [SAMPLE_BITS-1:0]  push_sample;
   logic                    full;
   logic                    pop;
   logic                    fifo_valid;
   logic [ENTRY_BITS-1:0]   push_data;
   logic [ENTRY_BITS-1:0]   pop_data;
   msg_kind_type            pop_kind;
   logic [SAMPLE_BITS-1:0]  pop_sample;

   assign push_data  = {push_kind, push_sample};
   assign pop_kind   = msg_kind_type'(pop_data[ENTRY_BITS-1:SAMPLE_BITS]);
   assign pop_sample = pop_data[SAMPLE_BITS-1:0];

   // command recognizer, link machine and timer
   scar_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_rx_byte    (req_rx_byte),
      .req_adc_sample (req_adc_sample),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .push           (push),
      .push_kind      (push_kind),
      .push_sample    (push_sample),
      .full           (full)
   );

   // reply queue
   scar_fifo #(
      .DATA_BITS (ENTRY_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .valid     (fifo_valid)
   );

   // reply transmitter
   scar_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_valid  (fifo_valid),
      .fifo_kind   (pop_kind),
      .fifo_sample (pop_sample),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/scar_fifo.sv =====
`default_nettype none

module scar_fifo #(
   parameter int DATA_BITS = 14
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire logic [DATA_BITS-1:0] push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic [DATA_BITS-1:0]      pop_data,
   output logic                      valid
);
   import scar_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/scar_front.sv =====
`default_nettype none

module scar_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIMER_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [7:0]                    req_rx_byte,
   input  wire logic [SAMPLE_BITS-1:0]        req_adc_sample,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [scar_pkg::CFG_BITS-1:0] csr_data,
   output logic                               push,
   output scar_pkg::msg_kind_type             push_kind,
   output logic [SAMPLE_BITS-1:0]             push_sample,
   input  wire logic                          full
);
   import scar_pkg::*;

   parse_state_type         parse_ff, parse_in;
   link_state_type          link_ff, link_in;
   logic                    ok_seen_ff, ok_seen_in;
   logic                    reset_seen_ff, reset_seen_in;
   logic [SAMPLE_BITS-1:0]  held_ff, held_in;
   logic [TIMER_BITS-1:0]   retry_count_ff, retry_count_in;
   logic                    expired_ff, expired_in;
   logic [CFG_BITS-1:0]     retry_ticks_ff, retry_ticks_in;

   logic                    accept;
   logic                    eol;
   logic [7:0]              want;
   parse_state_type         want_next;

   assign req_stall = full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !full;
   assign eol       = (req_rx_byte == CH_CR) || (req_rx_byte == CH_LF);

   // expected byte and successor for the letter states
   always_comb begin
      want      = CH_HASH;
      want_next = P_IDLE;
      case (parse_ff)
         P_R:     begin want = CH_S;    want_next = P_S;      end
         P_S:     begin want = CH_T;    want_next = P_T;      end
         P_T:     begin want = CH_HASH; want_next = P_DONE_T; end
         P_O:     begin want = CH_K;    want_next = P_K;      end
         P_K:     begin want = CH_HASH; want_next = P_DONE_K; end
         default: begin want = CH_HASH; want_next = P_IDLE;   end
      endcase
   end

   // recognizer, link machine and retry timer
   always_comb begin
      parse_in       = parse_ff;
      link_in        = link_ff;
      ok_seen_in     = ok_seen_ff;
      reset_seen_in  = reset_seen_ff;
      held_in        = held_ff;
      retry_count_in = retry_count_ff;
      expired_in     = expired_ff;
      retry_ticks_in = csr_valid ? csr_data : retry_ticks_ff;
      push           = 1'b0;
      push_kind      = MSG_REPORT;
      push_sample    = held_ff;

      if (accept) begin
         case (op_type'(req_operation))
            OP_BYTE: begin
               case (parse_ff)
                  P_IDLE: begin
                     if (req_rx_byte == CH_BANG) begin
                        parse_in = P_BANG;
                     end else if (eol) begin
                        link_in = L_ERROR;
                     end
                  end
                  P_BANG: begin
                     if (req_rx_byte == CH_R) begin
                        parse_in = P_R;
                     end else if (req_rx_byte == CH_O) begin
                        parse_in = P_O;
                     end else if (eol) begin
                        parse_in = P_IDLE;
                        link_in  = L_ERROR;
                     end
                  end
                  P_DONE_K: begin
                     if (eol) begin
                        ok_seen_in = 1'b1;
                        link_in    = L_WAIT;
                        parse_in   = P_IDLE;
                     end
                  end
                  P_DONE_T: begin
                     if (eol) begin
                        link_in  = L_REPORT;
                        parse_in = P_IDLE;
                     end
                  end
                  P_R, P_S, P_T, P_O, P_K: begin
                     if (req_rx_byte == want) begin
                        parse_in = want_next;
                        if (want_next == P_DONE_T) begin
                           reset_seen_in = 1'b1;
                        end
                     end else if (eol) begin
                        parse_in = P_IDLE;
                        link_in  = L_ERROR;
                     end else if (req_rx_byte == CH_BANG) begin
                        parse_in = P_BANG;
                     end else begin
                        parse_in = P_IDLE;
                     end
                  end
                  default: parse_in = P_IDLE;
               endcase
            end
            OP_SERVICE: begin
               case (link_ff)
                  L_REPORT: begin
                     held_in     = req_adc_sample;
                     push        = 1'b1;
                     push_kind   = MSG_REPORT;
                     push_sample = req_adc_sample;
                     link_in     = L_LOAD;
                  end
                  L_LOAD: begin
                     retry_count_in = TIMER_BITS'(retry_ticks_ff);
                     expired_in     = 1'b0;
                     link_in        = L_WAIT;
                  end
                  L_WAIT: begin
                     if (expired_ff) begin
                        retry_count_in = TIMER_BITS'(retry_ticks_ff);
                        expired_in     = 1'b0;
                        push           = 1'b1;
                        push_kind      = MSG_REPORT;
                        push_sample    = held_ff;
                     end
                     if (ok_seen_ff) begin
                        link_in       = reset_seen_ff ? L_END : L_IDLE;
                        ok_seen_in    = 1'b0;
                        reset_seen_in = 1'b0;
                     end
                  end
                  L_END: begin
                     link_in   = L_IDLE;
                     push      = 1'b1;
                     push_kind = MSG_END;
                  end
                  L_ERROR: begin
                     link_in   = L_IDLE;
                     push      = 1'b1;
                     push_kind = MSG_WRONG;
                  end
                  default: ;
               endcase
            end
            OP_TICK: begin
               if (retry_count_ff != '0) begin
                  retry_count_in = retry_count_ff - TIMER_BITS'(1);
                  if (retry_count_ff == TIMER_BITS'(1)) begin
                     expired_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff       <= P_IDLE;
         link_ff        <= L_IDLE;
         ok_seen_ff     <= 1'b0;
         reset_seen_ff  <= 1'b0;
         held_ff        <= '0;
         retry_count_ff <= '0;
         expired_ff     <= 1'b0;
         retry_ticks_ff <= RETRY_RESET;
      end else begin
         parse_ff       <= parse_in;
         link_ff        <= link_in;
         ok_seen_ff     <= ok_seen_in;
         reset_seen_ff  <= reset_seen_in;
         held_ff        <= held_in;
         retry_count_ff <= retry_count_in;
         expired_ff     <= expired_in;
         retry_ticks_ff <= retry_ticks_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/scar_back.sv =====
`default_nettype none

module scar_back #(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fifo_valid,
   input  wire scar_pkg::msg_kind_type fifo_kind,
   input  wire logic [SAMPLE_BITS-1:0] fifo_sample,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_tx_byte,
   output logic                        rsp_last
);
   import scar_pkg::*;

   localparam int DIGITS   = max_digits(SAMPLE_BITS);
   localparam int CNT_BITS = $clog2(DIGITS + 1);
   localparam int IDX_BITS = $clog2(DIGITS);

   back_phase_type          phase_ff, phase_in;
   msg_kind_type            kind_ff, kind_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0]  conv_ff, conv_in;
   logic                    busy_ff, busy_in;
   logic [CNT_BITS-1:0]     dcnt_ff, dcnt_in;
   logic [3:0]              digit_ff [DIGITS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    out_free;
   logic                    emit;
   logic [7:0]              cur_byte;
   logic                    cur_last;
   logic [CNT_BITS-1:0]     dprev;
   logic [IDX_BITS-1:0]     rd_idx;
   logic [IDX_BITS-1:0]     wr_idx;
   logic [15:0]             v16;
   logic [32:0]             prod;
   logic [15:0]             q16;
   logic [15:0]             rem16;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_byte_ff;
   assign rsp_last    = rsp_last_ff;

   // one decimal digit per cycle by reciprocal multiply
   assign v16   = 16'(conv_ff);
   assign prod  = 33'(v16) * 33'(DIV10_MUL);
   assign q16   = 16'(prod >> DIV10_SHIFT);
   assign rem16 = v16 - ((q16 << 3) + (q16 << 1));

   assign dprev  = dcnt_ff - CNT_BITS'(1);
   assign rd_idx = dprev[IDX_BITS-1:0];
   assign wr_idx = dcnt_ff[IDX_BITS-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = out_free && (phase_ff != BK_IDLE) && !((phase_ff == BK_DIGIT) && busy_ff);

   // byte of the current position
   always_comb begin
      cur_byte = CH_LF;
      cur_last = 1'b0;
      case (phase_ff)
         BK_HEAD: begin
            cur_byte = head_byte(kind_ff, pos_ff);
            cur_last = (pos_ff == head_last(kind_ff)) && (kind_ff != MSG_REPORT);
         end
         BK_DIGIT: begin
            cur_byte = CH_ZERO + {4'b0, digit_ff[rd_idx]};
         end
         BK_TAIL: begin
            cur_byte = tail_byte(pos_ff);
            cur_last = (pos_ff == TAIL_LAST);
         end
         default: ;
      endcase
   end

   // message sequencer and output register
   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      conv_in      = conv_ff;
      busy_in      = busy_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;

      if (out_free) begin
         rsp_valid_in = emit;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = cur_last;
      end

      // digit extraction runs while the leading text goes out
      if (busy_ff) begin
         conv_in = SAMPLE_BITS'(q16);
         dcnt_in = dcnt_ff + CNT_BITS'(1);
         busy_in = (q16 != '0);
      end

      if (emit) begin
         case (phase_ff)
            BK_HEAD: begin
               if (pos_ff == head_last(kind_ff)) begin
                  pos_in   = '0;
                  phase_in = (kind_ff == MSG_REPORT) ? BK_DIGIT : BK_IDLE;
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
               end
            end
            BK_DIGIT: begin
               dcnt_in = dprev;
               if (dcnt_ff == CNT_BITS'(1)) begin
                  phase_in = BK_TAIL;
                  pos_in   = '0;
               end
            end
            BK_TAIL: begin
               if (pos_ff == TAIL_LAST) begin
                  phase_in = BK_IDLE;
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
               end
            end
            default: ;
         endcase
      end

      pop = fifo_valid && ((phase_ff == BK_IDLE) || (emit && cur_last));
      if (pop) begin
         phase_in = BK_HEAD;
         kind_in  = fifo_kind;
         pos_in   = '0;
         conv_in  = fifo_sample;
         busy_in  = (fifo_kind == MSG_REPORT);
         dcnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= BK_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      conv_ff     <= conv_in;
      dcnt_ff     <= dcnt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // digit store, least significant first
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         digit_ff[wr_idx] <= rem16[3:0];
      end
   end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
   import scar_pkg::*;

   // operation code that the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 12;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 20;

   // reply predictor and checker
   class reply_scoreboard;
      typedef struct {
         logic [7:0] tx_byte;
         logic       last;
      } tx_item_type;

      logic [15:0]     retry_ticks;
      parse_state_type parse;
      link_state_type  link;
      bit              ok_seen;
      bit              rst_seen;
      logic [11:0]     held;
      logic [15:0]     retry_count;
      bit              expired;
      int              errors;
      tx_item_type     pending[$];

      function new();
         retry_ticks = RETRY_RESET;
         parse = P_IDLE;
         link = L_IDLE;
         ok_seen = 0;
         rst_seen = 0;
         held = '0;
         retry_count = '0;
         expired = 0;
         errors = 0;
      endfunction

      function void set_retry(logic [15:0] v);
         retry_ticks = v;
      endfunction

      // queue one reply, last flag on its final byte
      function void push_text(string s);
         tx_item_type it;
         for (int i = 0; i < s.len(); i++) begin
            it.tx_byte = s[i];
            it.last = (i == s.len() - 1);
            pending.push_back(it);
         end
      endfunction

      function void send_report();
         push_text($sformatf("!ADC=%0d#\r\n", held));
      endfunction

      function void reload();
         retry_count = retry_ticks;
         expired = 0;
      endfunction

      // command recognizer
      function void parse_byte(logic [7:0] c);
         logic            eol;
         logic [7:0]      want;
         parse_state_type nxt;
         eol = (c == CH_CR) || (c == CH_LF);
         want = 8'h00;
         nxt = P_IDLE;
         case (parse)
            P_IDLE: begin
               if (c == CH_BANG) parse = P_BANG;
               else if (eol) link = L_ERROR;
            end
            P_BANG: begin
               if (c == CH_R) parse = P_R;
               else if (c == CH_O) parse = P_O;
               else if (eol) begin
                  parse = P_IDLE;
                  link = L_ERROR;
               end
            end
            P_DONE_K: begin
               if (eol) begin
                  ok_seen = 1;
                  link = L_WAIT;
                  parse = P_IDLE;
               end
            end
            P_DONE_T: begin
               if (eol) begin
                  link = L_REPORT;
                  parse = P_IDLE;
               end
            end
            P_R: begin want = CH_S; nxt = P_S; end
            P_S: begin want = CH_T; nxt = P_T; end
            P_T: begin want = CH_HASH; nxt = P_DONE_T; end
            P_O: begin want = CH_K; nxt = P_K; end
            P_K: begin want = CH_HASH; nxt = P_DONE_K; end
            default: parse = P_IDLE;
         endcase
         // letter states: match, early line end, restart or drop
         if (want != 8'h00) begin
            if (c == want) begin
               parse = nxt;
               if (nxt == P_DONE_T) rst_seen = 1;
            end else if (eol) begin
               parse = P_IDLE;
               link = L_ERROR;
            end else if (c == CH_BANG) begin
               parse = P_BANG;
            end else begin
               parse = P_IDLE;
            end
         end
      endfunction

      // one step of the link machine
      function void service(logic [11:0] sample);
         case (link)
            L_REPORT: begin
               held = sample;
               send_report();
               link = L_LOAD;
            end
            L_LOAD: begin
               reload();
               link = L_WAIT;
            end
            L_WAIT: begin
               if (expired) begin
                  reload();
                  send_report();
               end
               if (ok_seen) begin
                  link = rst_seen ? L_END : L_IDLE;
                  ok_seen = 0;
                  rst_seen = 0;
               end
            end
            L_END: begin
               link = L_IDLE;
               push_text("END\r\n");
            end
            L_ERROR: begin
               link = L_IDLE;
               push_text("WRONG\r\n");
            end
            default: ;
         endcase
      endfunction

      // accepted input item
      function void note_item(logic [1:0] op, logic [7:0] rx, logic [11:0] sample);
         case (op)
            OP_BYTE:    parse_byte(rx);
            OP_SERVICE: service(sample);
            OP_TICK: begin
               if (retry_count != 0) begin
                  retry_count = retry_count - 1'b1;
                  if (retry_count == 0) expired = 1;
               end
            end
            default: ;
         endcase
      endfunction

      // accepted result item
      function void check_reply(logic [7:0] tx_byte, logic last);
         tx_item_type exp_item;
         if (pending.size() == 0) begin
            $error("unexpected reply byte %h last %0b", tx_byte, last);
            errors++;
         end else begin
            exp_item = pending.pop_front();
            if (tx_byte !== exp_item.tx_byte) begin
               $error("tx_byte: expected %h, got %h", exp_item.tx_byte, tx_byte);
               errors++;
            end
            if (last !== exp_item.last) begin
               $error("last: expected %0b, got %0b", exp_item.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_operation;
   logic [7:0]          req_rx_byte;
   logic [11:0]         req_adc_sample;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_tx_byte;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data;

   reply_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_done = 0;
   logic want_hold;
   logic hold_done;
   int hold_left;

   serial_command_ack_responder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_rx_byte    (req_rx_byte),
      .req_adc_sample (req_adc_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: check replies, random stall, one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_reply(rsp_tx_byte, rsp_last);
      if (want_hold && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offer one item with an optional idle gap, return at its acceptance
   task automatic send_item(input logic [1:0] op, input logic [7:0] rx,
                            input logic [11:0] sample);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= rx;
      req_adc_sample <= sample;
      do @(posedge clock); while (req_stall);
      sb.note_item(op, rx, sample);
      if (op != OP_UNUSED) items_done++;
   endtask

   task automatic write_retry(input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_retry(v);
   endtask

   // all replies in, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [11:0] rand_sample();
      if ($urandom_range(3) != 0) return 12'($urandom_range(4095));
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'd9;
         3: return 12'd10;
         4: return 12'd999;
         default: return 12'd1000;
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      string alpha = "!RSTOK#\r\nx";
      if ($urandom_range(1) != 0) return alpha[$urandom_range(alpha.len() - 1)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] rand_eol();
      return ($urandom_range(1) != 0) ? CH_CR : CH_LF;
   endfunction

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i], rand_sample());
   endtask

   task automatic service_step();
      send_item(OP_SERVICE, rand_byte(), rand_sample());
   endtask

   // one random sequence: mostly full command exchanges, some broken ones and noise
   task automatic random_scenario();
      string cmd;
      int    pick;
      int    cut;
      pick = $urandom_range(9);
      if (pick <= 4) begin
         // reset command, report, retries, then usually ok
         send_text("!RST#");
         send_item(OP_BYTE, rand_eol(), rand_sample());
         service_step();
         service_step();
         repeat ($urandom_range(3)) begin
            repeat ($urandom_range(4)) send_item(OP_TICK, rand_byte(), rand_sample());
            service_step();
         end
         if ($urandom_range(4) != 0) begin
            send_text("!OK#");
            send_item(OP_BYTE, rand_eol(), rand_sample());
            service_step();
            service_step();
         end
      end else if (pick <= 6) begin
         // ok with no reset before it
         send_text("!OK#");
         send_item(OP_BYTE, rand_eol(), rand_sample());
         service_step();
         service_step();
      end else if (pick == 7) begin
         // cut-off command
         if ($urandom_range(1) != 0) cmd = "!RST#";
         else cmd = "!OK#";
         cut = $urandom_range(1, cmd.len() - 1);
         send_text(cmd.substr(0, cut - 1));
         case ($urandom_range(2))
            0: send_item(OP_BYTE, rand_eol(), rand_sample());
            1: send_item(OP_BYTE, CH_BANG, rand_sample());
            default: send_item(OP_BYTE, 8'($urandom_range(255)), rand_sample());
         endcase
         service_step();
      end else begin
         // noise of every operation
         repeat ($urandom_range(1, 4))
            send_item(2'($urandom_range(3)), rand_byte(), rand_sample());
      end
   endtask

   task automatic random_phase();
      int start;
      start = items_done;
      while (items_done - start < PHASE_ITEMS) random_scenario();
   endtask

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int send_pcts[4];
      int stall_pcts[4];
      logic [15:0] retry_vals[4];
      send_pcts = '{0, 86, 0, 25};
      stall_pcts = '{0, 0, 86, 25};
      retry_vals = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 6))};
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_BYTE;
      req_rx_byte <= 8'h00;
      req_adc_sample <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      want_hold <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored items, early line end, full reset and ok exchange
      write_retry(16'd2);
      send_item(OP_UNUSED, 8'hFF, 12'hFFF);
      send_item(OP_BYTE, 8'hFF, 12'd0);
      send_item(OP_BYTE, 8'h00, 12'd0);
      send_item(OP_BYTE, CH_LF, 12'd0);
      send_item(OP_SERVICE, 8'h00, 12'd4095);
      send_text("!RST#");
      send_item(OP_BYTE, CH_CR, 12'd0);
      send_item(OP_SERVICE, 8'h00, 12'd4095);
      send_item(OP_SERVICE, 8'h00, 12'd0);
      send_item(OP_TICK, 8'h00, 12'd0);
      send_item(OP_TICK, 8'h00, 12'd0);
      send_item(OP_SERVICE, 8'h00, 12'd0);
      send_text("!OK#");
      send_item(OP_BYTE, CH_LF, 12'd0);
      send_item(OP_SERVICE, 8'h00, 12'd0);
      send_item(OP_SERVICE, 8'h00, 12'd0);
      wait_drained();

      // random phases, one idle pattern and retry setting each
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_pcts[m];
         stall_pct = stall_pcts[m];
         write_retry(retry_vals[m]);
         if (m == 0) begin
            // long receiver hold-off while error replies pile up
            want_hold <= 1'b1;
            repeat (4) begin
               send_item(OP_BYTE, CH_CR, rand_sample());
               service_step();
            end
         end
         random_phase();
         wait_drained();
      end

      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
